// ===== hw/rtl/s12rfc_pkg.sv =====
// s12rfc_pkg: shared constants, codes and the byte-wide crc step for the
// sdi-12 response frame checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package s12rfc_pkg;

  localparam int MAX_FRAME  = 128;
  localparam int TAIL_DEPTH = 5;

  localparam logic [7:0]  CHR_CR   = 8'h0D;
  localparam logic [7:0]  CHR_LF   = 8'h0A;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  SIX_BITS = 8'h3F;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNEXP    = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic REG_SENSOR_ADDRESS = 1'b0;
  localparam logic REG_CRC_ENABLED    = 1'b1;

  localparam logic [7:0] ADDR_RESET = 8'd48;
  localparam logic [7:0] MIN_CRC_LEN = 8'd6;

  typedef struct packed {
    logic [15:0] crc_computed;
    logic [15:0] crc_received;
    logic [7:0]  frame_length;
    logic [1:0]  frame_status;
  } frame_res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] acc_in, input logic [7:0] b);
    logic [15:0] acc;
    acc = acc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sdi12_response_frame_checker.sv =====
// sdi12_response_frame_checker: top level, byte stream in, one frame result out
// depends on s12rfc_pkg
`timescale 1ns / 1ps
`default_nettype none
// Takes one received response byte per transfer and gives one result per frame,
// at CR LF (from the second byte on) or as an overflow once the frame reaches
// s12rfc_pkg::MAX_FRAME bytes. Each byte goes through an input register and one
// combinational evaluation stage (crc step, address and length checks) into the
// result register, so a byte is accepted every cycle and a result is loaded into
// the result register when the byte that ends its frame leaves the input register;
// only a stalled result register holds the input back. Configuration writes take
// effect at the next frame end.
module sdi12_response_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // frame_status[1:0], frame_length[9:2],
                                       // crc_received[25:10], crc_computed[41:26], zero
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0]  addr_r;
  logic        crc_en_r;
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic [7:0]  tail_r [s12rfc_pkg::TAIL_DEPTH];
  logic [7:0]  tail_nxt [s12rfc_pkg::TAIL_DEPTH];
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        out_v_r, out_v_nxt;
  s12rfc_pkg::frame_res_t res_r, res_nxt;

  logic        consume;
  logic [7:0]  first_cur;
  logic [15:0] acc_cur;
  logic [7:0]  count;
  logic        ends;
  logic        long_enough;
  logic [17:0] rcv_sum;
  logic [15:0] rcv;
  logic [1:0]  status;

  assign consume   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || consume;

  always_comb begin
    first_cur   = (cnt_r == 8'd0) ? in_byte_r : first_r;
    acc_cur     = (cnt_r >= 8'(s12rfc_pkg::TAIL_DEPTH))
                  ? s12rfc_pkg::crc_feed(acc_r, tail_r[s12rfc_pkg::TAIL_DEPTH-1]) : acc_r;
    count       = cnt_r + 8'd1;
    ends        = (count >= 8'd2) && (in_byte_r == s12rfc_pkg::CHR_LF)
                  && (tail_r[0] == s12rfc_pkg::CHR_CR);
    long_enough = count >= s12rfc_pkg::MIN_CRC_LEN;
    // before the shift, the three crc characters sit in entries 3, 2 and 1
    rcv_sum     = ({10'd0, tail_r[3] & s12rfc_pkg::SIX_BITS} << 12)
                + ({10'd0, tail_r[2] & s12rfc_pkg::SIX_BITS} << 6)
                +  {10'd0, tail_r[1] & s12rfc_pkg::SIX_BITS};
    rcv         = (crc_en_r && long_enough) ? rcv_sum[15:0] : 16'd0;
    priority if (first_cur != addr_r || (crc_en_r && !long_enough)) begin
      status = s12rfc_pkg::ST_UNEXP;
    end else if (crc_en_r && rcv != acc_cur) begin
      status = s12rfc_pkg::ST_CRC_BAD;
    end else begin
      status = s12rfc_pkg::ST_OK;
    end
  end

  always_comb begin
    tail_nxt  = tail_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    res_nxt   = res_r;
    out_v_nxt = out_v_r && !out_tready;
    if (consume) begin
      if (ends || count >= 8'(s12rfc_pkg::MAX_FRAME)) begin
        for (int i = 0; i < s12rfc_pkg::TAIL_DEPTH; i++) begin
          tail_nxt[i] = 8'd0;
        end
        acc_nxt   = 16'd0;
        cnt_nxt   = 8'd0;
        first_nxt = 8'd0;
        out_v_nxt = 1'b1;
        res_nxt.crc_computed = acc_cur;
        if (ends) begin
          res_nxt.frame_status = status;
          res_nxt.frame_length = count;
          res_nxt.crc_received = rcv;
        end else begin
          res_nxt.frame_status = s12rfc_pkg::ST_OVERFLOW;
          res_nxt.frame_length = 8'(s12rfc_pkg::MAX_FRAME);
          res_nxt.crc_received = 16'd0;
        end
      end else begin
        for (int i = s12rfc_pkg::TAIL_DEPTH - 1; i > 0; i--) begin
          tail_nxt[i] = tail_r[i-1];
        end
        tail_nxt[0] = in_byte_r;
        acc_nxt     = acc_cur;
        cnt_nxt     = count;
        first_nxt   = first_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= s12rfc_pkg::ADDR_RESET;
      crc_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        s12rfc_pkg::REG_SENSOR_ADDRESS: addr_r   <= cfg_wdata;
        s12rfc_pkg::REG_CRC_ENABLED:    crc_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= 16'd0;
      cnt_r   <= 8'd0;
      first_r <= 8'd0;
      for (int i = 0; i < s12rfc_pkg::TAIL_DEPTH; i++) begin
        tail_r[i] <= 8'd0;
      end
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      out_v_r <= out_v_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, res_r};

endmodule
`default_nettype wire

// ===== hw/rtl/s12rfc_checker.sv =====
// s12rfc_checker: port-level assertions for the sdi-12 response frame checker
// depends on s12rfc_pkg; bound to sdi12_response_frame_checker
`timescale 1ns / 1ps
`default_nettype none
module s12rfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // overflow always reports the full frame length and no received crc
  a_overflow_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == s12rfc_pkg::ST_OVERFLOW |->
      out_tdata[9:2] == 8'(s12rfc_pkg::MAX_FRAME) && out_tdata[25:10] == 16'd0)
    else $error("overflow result malformed");

  // a terminated frame holds at least cr lf
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != s12rfc_pkg::ST_OVERFLOW |-> out_tdata[9:2] >= 8'd2)
    else $error("terminated frame too short");

  // a received crc only comes from a frame long enough to carry one
  a_rcv_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[25:10] != 16'd0 |-> out_tdata[9:2] >= s12rfc_pkg::MIN_CRC_LEN)
    else $error("received crc on short frame");

endmodule

bind sdi12_response_frame_checker s12rfc_checker u_s12rfc_checker (.*);
`default_nettype wire

// ===== bench/sdi12_response_frame_checker_tb.sv =====
// sdi12_response_frame_checker_tb: self-checking bench for the sdi-12 response frame checker,
// byte frames in, per-frame status, length and crc fields checked against a cycle-free scoreboard model
// depends on s12rfc_pkg and sdi12_response_frame_checker
`timescale 1ns / 1ps
module sdi12_response_frame_checker_tb;

  class frame_scoreboard;
    logic [7:0]  sensor_addr;
    bit          crc_on;
    logic [7:0]  tail [s12rfc_pkg::TAIL_DEPTH];
    logic [15:0] crc_acc;
    logic [7:0]  byte_cnt;
    logic [7:0]  lead_byte;
    s12rfc_pkg::frame_res_t expected_frames [$];
    int          errors;
    int          checked;
    int          overflows;
    int          crc_frames;

    function new();
      sensor_addr = s12rfc_pkg::ADDR_RESET;
      crc_on      = 1'b0;
      errors      = 0;
      checked     = 0;
      overflows   = 0;
      crc_frames  = 0;
      clear_frame();
    endfunction

    static function logic [15:0] arc16_next(logic [15:0] crc, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb  = crc[0] ^ d[i];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ s12rfc_pkg::CRC_POLY;
        end
      end
      return crc;
    endfunction

    function void clear_frame();
      foreach (tail[i]) tail[i] = 8'h00;
      crc_acc   = 16'h0000;
      byte_cnt  = 8'd0;
      lead_byte = 8'h00;
    endfunction

    function void set_config(logic [7:0] addr, bit crc);
      sensor_addr = addr;
      crc_on      = crc;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [7:0] prev;
      s12rfc_pkg::frame_res_t r;
      prev = tail[0];
      if (byte_cnt == 8'd0) begin
        lead_byte = b;
      end
      // a byte joins the crc only once five newer ones are behind it
      if (byte_cnt >= s12rfc_pkg::TAIL_DEPTH) begin
        crc_acc = arc16_next(crc_acc, tail[s12rfc_pkg::TAIL_DEPTH-1]);
      end
      for (int i = s12rfc_pkg::TAIL_DEPTH - 1; i > 0; i--) tail[i] = tail[i-1];
      tail[0]  = b;
      byte_cnt = byte_cnt + 8'd1;
      if (byte_cnt >= 8'd2 && b == s12rfc_pkg::CHR_LF && prev == s12rfc_pkg::CHR_CR) begin
        r.frame_length = byte_cnt;
        r.crc_computed = crc_acc;
        r.crc_received = 16'h0000;
        if (crc_on && byte_cnt >= s12rfc_pkg::MIN_CRC_LEN) begin
          r.crc_received = {tail[4][3:0], tail[3][5:0], tail[2][5:0]};
        end
        if (lead_byte != sensor_addr || (crc_on && byte_cnt < s12rfc_pkg::MIN_CRC_LEN)) begin
          r.frame_status = s12rfc_pkg::ST_UNEXP;
        end else if (crc_on && r.crc_received != crc_acc) begin
          r.frame_status = s12rfc_pkg::ST_CRC_BAD;
        end else begin
          r.frame_status = s12rfc_pkg::ST_OK;
        end
        if (crc_on) begin
          crc_frames++;
        end
        expected_frames.push_back(r);
        clear_frame();
      end else if (byte_cnt >= s12rfc_pkg::MAX_FRAME) begin
        r.frame_status = s12rfc_pkg::ST_OVERFLOW;
        r.frame_length = 8'(s12rfc_pkg::MAX_FRAME);
        r.crc_received = 16'h0000;
        r.crc_computed = crc_acc;
        expected_frames.push_back(r);
        clear_frame();
      end
    endfunction

    function void check_frame_result(logic [47:0] word);
      s12rfc_pkg::frame_res_t got;
      s12rfc_pkg::frame_res_t want;
      got = word[41:0];
      if (expected_frames.size() == 0) begin
        $error("frame result with nothing expected: %h", word);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      checked++;
      if (want.frame_status == s12rfc_pkg::ST_OVERFLOW) begin
        overflows++;
      end
      if (got.frame_status != want.frame_status) begin
        $error("frame_status expected %0d actual %0d", want.frame_status, got.frame_status);
        errors++;
      end
      if (got.frame_length != want.frame_length) begin
        $error("frame_length expected %0d actual %0d", want.frame_length, got.frame_length);
        errors++;
      end
      if (got.crc_received != want.crc_received) begin
        $error("crc_received expected %h actual %h", want.crc_received, got.crc_received);
        errors++;
      end
      if (got.crc_computed != want.crc_computed) begin
        $error("crc_computed expected %h actual %h", want.crc_computed, got.crc_computed);
        errors++;
      end
      if (word[47:42] != 6'd0) begin
        $error("out_tdata padding expected 0 actual %h", word[47:42]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [7:0]  cfg_wdata  = 8'h00;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;

  frame_scoreboard sb;
  int burst_left    = 0;
  int bytes_sent    = 0;
  int hold_requests = 0;

  sdi12_response_frame_checker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #800000;
    $display("sdi12_response_frame_checker_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_frame_result(out_tdata);
    end
  end

  // receiver: windows of steady, random and sparse ready, plus long hold-offs on request
  initial begin : receiver
    int window;
    int mode;
    int hold_left;
    int holds_done;
    window     = 0;
    mode       = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        hold_left  = 300;
        holds_done = hold_requests;
      end
      if (window == 0) begin
        mode   = $urandom_range(0, 2);
        window = $urandom_range(20, 80);
      end
      window--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_rx_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] lead, input int body_len, input bit with_crc,
                            input bit spoil);
    logic [7:0]  q [$];
    logic [15:0] crc;
    int          k;
    q.push_back(lead);
    repeat (body_len) q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    if (with_crc) begin
      crc = 16'h0000;
      foreach (q[i]) crc = frame_scoreboard::arc16_next(crc, q[i]);
      q.push_back(8'h40 | {4'h0, crc[15:12]});
      q.push_back(8'h40 | {2'b00, crc[11:6]});
      q.push_back(8'h40 | {2'b00, crc[5:0]});
      if (spoil) begin
        k = q.size() - 1 - $urandom_range(0, 2);
        q[k][$urandom_range(0, 3)] = ~q[k][$urandom_range(0, 3)];
      end
    end
    q.push_back(s12rfc_pkg::CHR_CR);
    q.push_back(s12rfc_pkg::CHR_LF);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] addr, input bit crc);
    cfg_we    <= 1'b1;
    cfg_index <= s12rfc_pkg::REG_SENSOR_ADDRESS;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_index <= s12rfc_pkg::REG_CRC_ENABLED;
    cfg_wdata <= {7'd0, crc};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(addr, crc);
  endtask

  initial begin : stimulus
    logic [7:0] addr;
    bit         crc_on;
    int         start;
    int         pick;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: lf as first byte, plain frame, bare cr lf
    send_byte(s12rfc_pkg::CHR_LF);
    send_byte(s12rfc_pkg::CHR_CR);
    send_byte(s12rfc_pkg::CHR_LF);
    send_byte(s12rfc_pkg::ADDR_RESET);
    send_byte(s12rfc_pkg::CHR_CR);
    send_byte(s12rfc_pkg::CHR_LF);
    send_byte(s12rfc_pkg::CHR_CR);
    send_byte(s12rfc_pkg::CHR_LF);
    settle();
    // crc mode: too short, then a good crc frame
    write_config(8'hFF, 1'b1);
    send_byte(8'hFF);
    send_byte(s12rfc_pkg::CHR_CR);
    send_byte(s12rfc_pkg::CHR_LF);
    send_frame(8'hFF, 1, 1'b1, 1'b0);
    settle();
    // address mismatch with crc, then a frame whose crc may be spoiled, both at the minimum length
    write_config(8'h00, 1'b1);
    send_frame(8'h01, 0, 1'b1, 1'b0);
    send_frame(8'h00, 0, 1'b1, 1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: addr = 8'h00;
        1: addr = 8'hFF;
        2: addr = s12rfc_pkg::ADDR_RESET;
        default: addr = 8'($urandom_range(0, 255));
      endcase
      crc_on = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      write_config(addr, crc_on);
      if (phase == 3) begin
        hold_requests++;
      end
      if (phase == 2) begin
        send_frame(addr, 127, 1'b0, 1'b0);
      end
      start = bytes_sent;
      while (bytes_sent - start < 125) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_frame(addr, $urandom_range(0, 12), crc_on, 1'b0);
        end else if (pick < 58) begin
          send_frame(addr, $urandom_range(0, 12), !crc_on, 1'b0);
        end else if (pick < 68) begin
          send_frame(addr, $urandom_range(0, 12), 1'b1, 1'b1);
        end else if (pick < 76) begin
          send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), crc_on, 1'b0);
        end else if (pick < 84) begin
          send_frame(addr, $urandom_range(0, 2), 1'b0, 1'b0);
        end else if (pick < 96) begin
          repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) begin
            send_byte(s12rfc_pkg::CHR_CR);
            send_byte(s12rfc_pkg::CHR_LF);
          end
        end else begin
          send_frame(addr, $urandom_range(118, 128), crc_on, 1'b0);
        end
      end
      settle();
    end

    $display("%0d bytes transferred in, %0d frame results checked", bytes_sent, sb.checked);
    $display("%0d overflows, %0d frames ended in crc mode", sb.overflows, sb.crc_frames);
    if (sb.errors == 0) begin
      $display("sdi12_response_frame_checker_tb passed");
    end else begin
      $display("sdi12_response_frame_checker_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/s12rfc_pkg.sv
hw/rtl/sdi12_response_frame_checker.sv
hw/rtl/s12rfc_checker.sv
bench/sdi12_response_frame_checker_tb.sv
